// File: rtl/fpa_pkg.sv
// Package with the word types and opcodes of the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic               overflow;
		logic               divide_by_zero;
	} out_word_t;

endpackage
`default_nettype wire

// File: rtl/fpa_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div #(
	parameter int NB = 64,
	parameter int DB = 33
) (
	input  wire logic          clk,
	input  wire logic [NB-1:0] num,
	input  wire logic [DB-1:0] den,
	output logic [NB-1:0]      quo
);
	// Each stage holds the partial remainder, the remaining dividend bits and the quotient.
	// The remainder stays below the divisor, so DB bits hold it.
	logic [DB-1:0] rem_q [1:NB-1];
	logic [NB-1:0] num_q [1:NB];
	logic [DB-1:0] den_q [1:NB-1];

	for (genvar i = 0; i < NB; i++) begin : g_st
		logic [DB-1:0] rin;
		logic [NB-1:0] nin;
		logic [DB-1:0] din;
		logic [DB:0]   sh;
		logic [DB:0]   df;
		logic          ge;
		if (i == 0) begin : g_first
			assign rin = '0;
			assign nin = num;
			assign din = den;
		end else begin : g_next
			assign rin = rem_q[i];
			assign nin = num_q[i];
			assign din = den_q[i];
		end
		assign sh = {rin, nin[NB-1]};
		assign df = sh - {1'b0, din};
		assign ge = (sh >= {1'b0, din});
		always_ff @(posedge clk) begin
			num_q[i+1] <= {nin[NB-2:0], ge};
		end
		if (i < NB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (ge) rem_q[i+1] <= df[DB-1:0];
				else rem_q[i+1] <= sh[DB-1:0];
				den_q[i+1] <= din;
			end
		end
	end

	// After all stages the dividend bits have been replaced by quotient bits.
	assign quo = num_q[NB];
endmodule
`default_nettype wire

// File: rtl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
//
//   port group   dir  handshake          payload
//   command      in   start & !busy      cmd   (fpa_pkg::in_word_t)
//   result       out  done, one cycle    rsp   (fpa_pkg::out_word_t)
//
// Every op raises done after the same delay from the edge that takes its word;
// the length is set by the divider, which resolves
// one quotient bit per stage, and all ops travel the same delay line so
// results stay in order. A new word enters every cycle.
// busy is always low. Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire fpa_pkg::in_word_t cmd,
	output logic                  done,
	output fpa_pkg::out_word_t    rsp
);
	localparam int EB  = (WORD_BITS > 32) ? 32 : WORD_BITS;
	localparam int NB  = 34 + FRAC_BITS;   // 2*|a|<<F
	localparam int DB  = 33;               // 2*|b|

	localparam logic signed [65:0] WMAX = (66'sd1 <<< (EB - 1)) - 66'sd1;
	localparam logic signed [65:0] WMIN = -WMAX - 66'sd1;

	assign busy = 1'b0;

	function automatic logic [32:0] sat(input logic signed [65:0] v);
		if (v > WMAX) return {1'b1, WMAX[31:0]};
		if (v < WMIN) return {1'b1, WMIN[31:0]};
		return {1'b0, v[31:0]};
	endfunction

	// Stage 1: register the command and magnitudes.
	logic               v_s1;
	logic [3:0]         op_s1;
	logic signed [31:0] a_s1, b_s1;
	logic [31:0]        ma_s1, mb_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		op_s1 <= cmd.op;
		a_s1  <= cmd.operand_a;
		b_s1  <= cmd.operand_b;
		ma_s1 <= cmd.operand_a[31] ? 32'(-cmd.operand_a) : 32'(cmd.operand_a);
		mb_s1 <= cmd.operand_b[31] ? 32'(-cmd.operand_b) : 32'(cmd.operand_b);
	end

	// Stage 2: product, simple ops; divider inputs.
	logic               v_s2;
	logic [3:0]         op_s2;
	logic [63:0]        p_s2;
	logic [32:0]        simp_s2;
	logic               cmp_s2, neg_s2, dz_s2;
	logic signed [31:0] a_s2;
	logic [NB-1:0]      dnum;
	logic [DB-1:0]      dden;
	logic signed [65:0] sa, sb;
	logic [32:0]        simp;
	logic               cmp;
	assign sa = 66'(a_s1);
	assign sb = 66'(b_s1);
	assign dnum = NB'({ma_s1, 1'b0}) << FRAC_BITS;
	assign dden = {mb_s1, 1'b0};

	always_comb begin
		simp = '0;
		cmp  = 1'b0;
		case (op_s1)
			fpa_pkg::OP_ADD:      simp = sat(sa + sb);
			fpa_pkg::OP_SUB:      simp = sat(sa - sb);
			fpa_pkg::OP_GT:       cmp = sa > sb;
			fpa_pkg::OP_LT:       cmp = sa < sb;
			fpa_pkg::OP_GE:       cmp = sa >= sb;
			fpa_pkg::OP_LE:       cmp = sa <= sb;
			fpa_pkg::OP_EQ:       cmp = sa == sb;
			fpa_pkg::OP_NE:       cmp = sa != sb;
			fpa_pkg::OP_MIN:      simp = sat((sa < sb) ? sa : sb);
			fpa_pkg::OP_MAX:      simp = sat((sa > sb) ? sa : sb);
			fpa_pkg::OP_INC:      simp = sat(sa + 66'sd1);
			fpa_pkg::OP_DEC:      simp = sat(sa - 66'sd1);
			fpa_pkg::OP_FROM_INT: simp = sat(sa <<< FRAC_BITS);
			fpa_pkg::OP_TO_INT:   simp = {1'b0, 32'(a_s1 >>> FRAC_BITS)};
			default:              simp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		p_s2    <= 64'(ma_s1) * 64'(mb_s1);
		simp_s2 <= simp;
		cmp_s2  <= cmp;
		neg_s2  <= a_s1[31] ^ b_s1[31];
		dz_s2   <= (b_s1 == 32'sd0);
		a_s2    <= a_s1;
	end

	// Stage 3: round the product.
	logic [64:0] half;
	assign half = (FRAC_BITS > 0) ? (65'd1 << (FRAC_BITS - 1)) : 65'd0;
	logic               v_s3;
	logic [3:0]         op_s3;
	logic [64:0]        pq_s3;
	logic [32:0]        simp_s3;
	logic               cmp_s3, neg_s3, dz_s3;
	logic signed [31:0] a_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		op_s3   <= op_s2;
		pq_s3   <= (65'(p_s2) + half) >> FRAC_BITS;
		simp_s3 <= simp_s2;
		cmp_s3  <= cmp_s2;
		neg_s3  <= neg_s2;
		dz_s3   <= dz_s2;
		a_s3    <= a_s2;
	end

	// Divider: quotient of (2n+d)/(2d) equals floor((2n+d)/(2d)); add d to numerator.
	logic [NB-1:0] qd;
	logic [NB-1:0] dnum_r;
	assign dnum_r = dnum + NB'(mb_s1);
	fpa_div #(.NB(NB), .DB(DB)) u_div (
		.clk(clk), .num(dnum_r), .den(dden), .quo(qd)
	);

	// Delay line for the non-divide result until the divider finishes.
	localparam int DL = NB - 2;
	logic [3:0]  op_d [1:DL];
	logic [64:0] pq_d [1:DL];
	logic [32:0] sm_d [1:DL];
	logic [DL:1] v_d;
	logic        cmp_d [1:DL], neg_d [1:DL], dz_d [1:DL];
	logic [1:0]  as_d [1:DL];
	for (genvar i = 1; i <= DL; i++) begin : g_dl
		if (i == 1) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_d[1] <= 1'b0;
				else v_d[1] <= v_s3;
			end
			always_ff @(posedge clk) begin
				op_d[1] <= op_s3; pq_d[1] <= pq_s3; sm_d[1] <= simp_s3;
				cmp_d[1] <= cmp_s3; neg_d[1] <= neg_s3; dz_d[1] <= dz_s3;
				as_d[1] <= {a_s3[31], (a_s3 == 32'sd0)};
			end
		end else begin : g_body
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_d[i] <= 1'b0;
				else v_d[i] <= v_d[i-1];
			end
			always_ff @(posedge clk) begin
				op_d[i] <= op_d[i-1]; pq_d[i] <= pq_d[i-1]; sm_d[i] <= sm_d[i-1];
				cmp_d[i] <= cmp_d[i-1]; neg_d[i] <= neg_d[i-1]; dz_d[i] <= dz_d[i-1];
				as_d[i] <= as_d[i-1];
			end
		end
	end

	// Final stage: sign, saturate, select.
	logic [65:0]        mq;
	logic signed [65:0] sv;
	logic [32:0]        fin;
	always_comb begin
		mq  = (op_d[DL] == fpa_pkg::OP_MUL) ? 66'(pq_d[DL]) : 66'(qd);
		sv  = neg_d[DL] ? -$signed(mq) : $signed(mq);
		fin = sat(sv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_d[DL];
	end
	always_ff @(posedge clk) begin
		rsp.compare_true <= cmp_d[DL];
		case (op_d[DL])
			fpa_pkg::OP_MUL: begin
				rsp.result_value   <= fin[31:0];
				rsp.overflow       <= fin[32];
				rsp.divide_by_zero <= 1'b0;
			end
			fpa_pkg::OP_DIV: begin
				rsp.divide_by_zero <= dz_d[DL];
				if (dz_d[DL]) begin
					rsp.overflow       <= 1'b0;
					rsp.result_value   <= as_d[DL][0] ? 32'd0 :
						(as_d[DL][1] ? WMIN[31:0] : WMAX[31:0]);
				end else begin
					rsp.result_value <= fin[31:0];
					rsp.overflow     <= fin[32];
				end
			end
			default: begin
				rsp.result_value   <= sm_d[DL][31:0];
				rsp.overflow       <= sm_d[DL][32];
				rsp.divide_by_zero <= 1'b0;
			end
		endcase
	end
endmodule
`default_nettype wire

// File: tb/fixed_point_alu_tb.sv
// Self-checking testbench for the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_tb;

	localparam int FRAC = 8;
	localparam int LAT = 43;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	fpa_pkg::in_word_t cmd = '0;
	fpa_pkg::out_word_t rsp;

	fpa_pkg::in_word_t pending_words[$];
	fpa_pkg::out_word_t alu_results_due[$];
	int sender_idle_pct = 17;
	int mismatches = 0;
	longint cycles = 0;

	fixed_point_alu #(.FRAC_BITS(FRAC), .WORD_BITS(32)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic longint clamp_word(longint v, ref bit ovf);
		if (v > WMAX) begin
			ovf = 1'b1;
			return WMAX;
		end
		if (v < WMIN) begin
			ovf = 1'b1;
			return WMIN;
		end
		return v;
	endfunction

	function automatic fpa_pkg::out_word_t alu_compute(fpa_pkg::in_word_t w);
		fpa_pkg::out_word_t o;
		longint a, b, r;
		longint unsigned ma, mb, p, q, n;
		bit ovf, neg;
		a = w.operand_a;
		b = w.operand_b;
		r = 0;
		ovf = 1'b0;
		o = '0;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		neg = (a < 0) != (b < 0);
		case (fpa_pkg::op_t'(w.op))
			fpa_pkg::OP_ADD: r = clamp_word(a + b, ovf);
			fpa_pkg::OP_SUB: r = clamp_word(a - b, ovf);
			fpa_pkg::OP_MUL: begin
				p = ma * mb;
				q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
				r = clamp_word(neg ? -longint'(q) : longint'(q), ovf);
			end
			fpa_pkg::OP_DIV: begin
				if (b == 0) begin
					o.divide_by_zero = 1'b1;
					r = a > 0 ? WMAX : (a < 0 ? WMIN : 0);
				end else begin
					n = ma << FRAC;
					q = (2 * n + mb) / (2 * mb);
					r = clamp_word(neg ? -longint'(q) : longint'(q), ovf);
				end
			end
			fpa_pkg::OP_GT: o.compare_true = a > b;
			fpa_pkg::OP_LT: o.compare_true = a < b;
			fpa_pkg::OP_GE: o.compare_true = a >= b;
			fpa_pkg::OP_LE: o.compare_true = a <= b;
			fpa_pkg::OP_EQ: o.compare_true = a == b;
			fpa_pkg::OP_NE: o.compare_true = a != b;
			fpa_pkg::OP_MIN: r = a < b ? a : b;
			fpa_pkg::OP_MAX: r = a > b ? a : b;
			fpa_pkg::OP_INC: r = clamp_word(a + 1, ovf);
			fpa_pkg::OP_DEC: r = clamp_word(a - 1, ovf);
			fpa_pkg::OP_FROM_INT: r = clamp_word(a <<< FRAC, ovf);
			default: r = a >>> FRAC;
		endcase
		o.result_value = r[31:0];
		o.overflow = ovf;
		return o;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? 32'd0 : 32'hffffffff;
			3, 4: return $urandom_range(0, 4096) - 2048;
			5: return {{8{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 24'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_word(fpa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
		fpa_pkg::in_word_t w;
		w.op = op;
		w.operand_a = a;
		w.operand_b = b;
		pending_words.push_back(w);
	endtask

	// Driver: a word is taken at an edge where start is high and busy low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!(start && busy)) begin
				if (pending_words.size() > 0 &&
						$urandom_range(0, 99) >= sender_idle_pct) begin
					cmd <= pending_words[0];
					alu_results_due.push_back(alu_compute(pending_words[0]));
					void'(pending_words.pop_front());
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result is matched against the oldest expectation.
	always @(posedge clk) begin
		fpa_pkg::out_word_t exp_w;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (alu_results_due.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result word %h", rsp);
			end else begin
				exp_w = alu_results_due.pop_front();
				if (rsp !== exp_w) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected val=%h cmp=%b ovf=%b dz=%b,",
							exp_w.result_value, exp_w.compare_true, exp_w.overflow,
							exp_w.divide_by_zero,
							" got val=%h cmp=%b ovf=%b dz=%b",
							rsp.result_value, rsp.compare_true,
							rsp.overflow, rsp.divide_by_zero);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [31:0] edge_vals[6];
		edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h100, 32'h80};
		// Directed: every op on edge values (field extremes and small powers of two), plus rounding ties and zero divisors.
		for (int k = 0; k < 16; k++)
			queue_word(fpa_pkg::op_t'(k), edge_vals[k % 6], edge_vals[(k + 1) % 6]);
		queue_word(fpa_pkg::OP_DIV, 32'h12345, 32'h0);
		queue_word(fpa_pkg::OP_DIV, 32'h0, 32'h0);
		queue_word(fpa_pkg::OP_DIV, 32'h80000000, 32'h0);
		queue_word(fpa_pkg::OP_MUL, 32'h180, 32'h1);
		queue_word(fpa_pkg::OP_MUL, 32'hfffffe80, 32'h1);
		queue_word(fpa_pkg::OP_DIV, 32'h1, 32'h200);
		queue_word(fpa_pkg::OP_DIV, 32'h80000000, 32'h1);
		queue_word(fpa_pkg::OP_EQ, 32'h5, 32'h5);
		queue_word(fpa_pkg::OP_TO_INT, 32'hffffff01, 32'h0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = phase == 0 ? 17 : (phase == 1 ? 78 : 0);
			for (int i = 0; i < 475; i++)
				queue_word(fpa_pkg::op_t'($urandom_range(0, 15)), pick_operand(),
					pick_operand());
			wait (pending_words.size() == 0 && alu_results_due.size() == 0);
		end
		repeat (LAT + 10) @(posedge clk);
		if (mismatches == 0 && alu_results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
